@@ rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
package ple_pkg;

	// Default list depth
	localparam int CAPACITY_DEF = 64;

	// Field widths fixed by the item format
	localparam int OP_W     = 2;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_DELETE   = 2'd1,
		OP_SEARCH   = 2'd2,
		OP_TRAVERSE = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_BADPOS = 3'd1,
		ST_FULL   = 3'd2,
		ST_MISS   = 3'd3,
		ST_EMPTY  = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_PUT,
		S_SEARCH,
		S_TRAV,
		S_RESP
	} state_t;

endpackage

@@ rtl/positional_list_engine.sv @@
// Positional list engine: ordered list of signed words with insert, delete, search, traverse.
//
// Keeps up to CAPACITY signed 32-bit words in one RAM with one write and one
// registered read per cycle; a small sequencer walks the RAM to shift,
// search or traverse entries and the input is stalled until the item is
// finished. Traverse emits one result per entry at one per cycle while
// the output is not stalled. Bad positions, a full list and an empty
// traverse answer without walking the RAM. The RAM port moves or compares
// one entry per cycle. The result sits in an output register, so the next
// item is taken while the last result still waits. The RAM needs no
// clearing after reset.
module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ple_pkg::OP_W-1:0]             operation,
	input  logic [ple_pkg::POS_W-1:0]            position,
	input  logic signed [ple_pkg::VAL_W-1:0]     value,
	// Output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ple_pkg::STATUS_W-1:0]         status,
	output logic [ple_pkg::INDEX_W-1:0]          index,
	output logic signed [ple_pkg::VAL_W-1:0]     element,
	output logic [ple_pkg::COUNT_W-1:0]          count,
	output logic                                 last
);

	import ple_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > POS_W) ? CW : POS_W;

	// Sequencer and list state
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [AW-1:0]   pos_q, pos_d;
	logic [VAL_W-1:0] val_q, val_d;
	status_t         res_status_q, res_status_d;
	logic [AW-1:0]   res_index_q, res_index_d;

	// Output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  index_q;
	logic [VAL_W-1:0]    element_q;
	logic [COUNT_W-1:0]  count_q;
	logic                last_q;

	// RAM port
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;

	// Output load
	logic             load_out;
	status_t          ld_status;
	logic [AW-1:0]    ld_index;
	logic [VAL_W-1:0] ld_element;
	logic             ld_last;

	logic          accept;
	logic          slot_free;
	logic [WW-1:0] pos_w, cnt_w;
	logic [AW-1:0] pos_a, last_idx;
	logic          at_last;

	ple_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign pos_w    = WW'(position);
	assign cnt_w    = WW'(cnt_q);
	assign pos_a    = AW'(pos_w);
	assign last_idx = AW'(cnt_q - CW'(1));
	assign at_last  = (ptr_q == last_idx);

	// State register and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		pos_q        <= pos_d;
		val_q        <= val_d;
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
	end

	// Next state, RAM control and output load
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		ptr_d        = ptr_q;
		pos_d        = pos_q;
		val_d        = val_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		ram_we       = 1'b0;
		ram_waddr    = ptr_q;
		ram_wdata    = ram_rdata;
		ram_re       = 1'b0;
		ram_raddr    = ptr_q;
		load_out     = 1'b0;
		ld_status    = ST_OK;
		ld_index     = '0;
		ld_element   = '0;
		ld_last      = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_d       = pos_a;
					val_d       = value;
					res_index_d = '0;
					unique case (op_t'(operation))
						OP_INSERT: begin
							if (pos_w > cnt_w) begin
								res_status_d = ST_BADPOS;
								state_d      = S_RESP;
							end else if (cnt_q == CW'(CAPACITY)) begin
								res_status_d = ST_FULL;
								state_d      = S_RESP;
							end else if (pos_w == cnt_w) begin
								state_d = S_PUT;
							end else begin
								// walk down from the top entry
								ram_re    = 1'b1;
								ram_raddr = last_idx;
								ptr_d     = last_idx;
								state_d   = S_SHIFT_UP;
							end
						end
						OP_DELETE: begin
							if (pos_w >= cnt_w) begin
								res_status_d = ST_BADPOS;
								state_d      = S_RESP;
							end else if (pos_a == last_idx) begin
								cnt_d        = cnt_q - CW'(1);
								res_status_d = ST_OK;
								state_d      = S_RESP;
							end else begin
								// walk up from the entry above the hole
								ram_re    = 1'b1;
								ram_raddr = pos_a + AW'(1);
								ptr_d     = pos_a + AW'(1);
								state_d   = S_SHIFT_DN;
							end
						end
						OP_SEARCH: begin
							if (cnt_q == '0) begin
								res_status_d = ST_MISS;
								state_d      = S_RESP;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								ptr_d     = '0;
								state_d   = S_SEARCH;
							end
						end
						OP_TRAVERSE: begin
							if (cnt_q == '0) begin
								res_status_d = ST_EMPTY;
								state_d      = S_RESP;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								ptr_d     = '0;
								state_d   = S_TRAV;
							end
						end
					endcase
				end
			end

			// rdata holds entry ptr; move it one place up
			S_SHIFT_UP: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + AW'(1);
				ram_wdata = ram_rdata;
				if (ptr_q == pos_q) begin
					state_d = S_PUT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q - AW'(1);
					ptr_d     = ptr_q - AW'(1);
				end
			end

			// rdata holds entry ptr; move it one place down
			S_SHIFT_DN: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q - AW'(1);
				ram_wdata = ram_rdata;
				if (at_last) begin
					cnt_d        = cnt_q - CW'(1);
					res_status_d = ST_OK;
					state_d      = S_RESP;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q + AW'(1);
					ptr_d     = ptr_q + AW'(1);
				end
			end

			// write the new value into the opened slot
			S_PUT: begin
				ram_we       = 1'b1;
				ram_waddr    = pos_q;
				ram_wdata    = val_q;
				cnt_d        = cnt_q + CW'(1);
				res_status_d = ST_OK;
				state_d      = S_RESP;
			end

			// one compare per cycle, lowest index first
			S_SEARCH: begin
				if (ram_rdata == val_q) begin
					res_status_d = ST_OK;
					res_index_d  = ptr_q;
					state_d      = S_RESP;
				end else if (at_last) begin
					res_status_d = ST_MISS;
					state_d      = S_RESP;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q + AW'(1);
					ptr_d     = ptr_q + AW'(1);
				end
			end

			// emit one entry per free output slot; rdata holds while stalled
			S_TRAV: begin
				if (slot_free) begin
					load_out   = 1'b1;
					ld_status  = ST_OK;
					ld_index   = ptr_q;
					ld_element = ram_rdata;
					ld_last    = at_last;
					if (at_last) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = ptr_q + AW'(1);
						ptr_d     = ptr_q + AW'(1);
					end
				end
			end

			// single result for insert, delete, search and empty traverse
			S_RESP: begin
				if (slot_free) begin
					load_out  = 1'b1;
					ld_status = res_status_q;
					ld_index  = res_index_q;
					state_d   = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q  <= ld_status;
			index_q   <= INDEX_W'(ld_index);
			element_q <= ld_element;
			count_q   <= COUNT_W'(cnt_q);
			last_q    <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign index     = index_q;
	assign element   = element_q;
	assign count     = count_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	// the entry count never passes the list depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// an accepted item holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled after accept");

	// a new result is never loaded over one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !load_out)
		else $error("stalled result overwritten");

	// every RAM write stays inside the list
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr <= AW'(CAPACITY - 1)))
		else $error("RAM write beyond capacity");
`endif

endmodule

@@ rtl/ple_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ verif/tb_positional_list_engine.sv @@
// Self-checking testbench for the positional list engine: directed, pressure and random items.
`timescale 1ns / 1ps

module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int DEPTH = ple_pkg::CAPACITY_DEF;

	// One expected result of the list engine
	typedef struct {
		status_t             status;
		logic [INDEX_W-1:0]  index;
		logic [VAL_W-1:0]    element;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} list_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [OP_W-1:0]          operation;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;
	logic                     out_valid;
	logic                     out_stall;
	logic [STATUS_W-1:0]      status;
	logic [INDEX_W-1:0]       index;
	logic signed [VAL_W-1:0]  element;
	logic [COUNT_W-1:0]       count;
	logic                     last;

	// Shadow copy of the list and the results it predicts
	logic signed [VAL_W-1:0]  shadow_list[$];
	list_result_t             pending_results[$];

	int  items_sent;
	int  results_checked;
	int  traversals;
	int  peak_length;
	int  mismatches;
	bit  tx_quiet;
	bit  rx_quiet;
	int  rx_hold;

	positional_list_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.index     (index),
		.element   (element),
		.count     (count),
		.last      (last)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

	// Queue one expected result
	function automatic void push_result(status_t st, int idx, logic [VAL_W-1:0] elem, int cnt,
			logic lst);
		list_result_t r;
		r.status  = st;
		r.index   = idx[INDEX_W-1:0];
		r.element = elem;
		r.count   = cnt[COUNT_W-1:0];
		r.last    = lst;
		pending_results.push_back(r);
	endfunction

	// Apply one accepted operation to the shadow list and predict its results
	function automatic void apply_list_op(op_t op, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
		int n;
		int hit;
		n = shadow_list.size();
		hit = -1;
		case (op)
			OP_INSERT: begin
				if (pos > n)
					push_result(ST_BADPOS, 0, '0, n, 1'b1);
				else if (n >= DEPTH)
					push_result(ST_FULL, 0, '0, n, 1'b1);
				else begin
					shadow_list.insert(pos, val);
					push_result(ST_OK, 0, '0, n + 1, 1'b1);
				end
			end
			OP_DELETE: begin
				if (pos >= n)
					push_result(ST_BADPOS, 0, '0, n, 1'b1);
				else begin
					shadow_list.delete(pos);
					push_result(ST_OK, 0, '0, n - 1, 1'b1);
				end
			end
			OP_SEARCH: begin
				for (int i = n - 1; i >= 0; i--)
					if (shadow_list[i] == val) hit = i;
				if (hit >= 0)
					push_result(ST_OK, hit, '0, n, 1'b1);
				else
					push_result(ST_MISS, 0, '0, n, 1'b1);
			end
			default: begin
				traversals++;
				if (n == 0)
					push_result(ST_EMPTY, 0, '0, 0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						push_result(ST_OK, i, shadow_list[i], n, i == n - 1);
			end
		endcase
		if (shadow_list.size() > peak_length) peak_length = shadow_list.size();
	endfunction

	// Offer one item after a random gap; returns at the edge that takes it
	task automatic send_item(op_t op, logic [POS_W-1:0] pos, logic signed [VAL_W-1:0] val);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		position  <= pos;
		value     <= val;
		do @(posedge clk); while (in_stall);
		apply_list_op(op, pos, val);
		items_sent++;
	endtask

	// Stop offering and wait for every predicted result
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Value mix: extremes, near-zero duplicates and full random words
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
			3, 4: return $signed($urandom_range(0, 8)) - 32'sd4;
			default: return $urandom;
		endcase
	endfunction

	// Operations on an empty list
	task automatic test_empty_list();
		send_item(OP_TRAVERSE, 7'd0, 32'sd0);
		send_item(OP_DELETE, 7'd0, 32'sd0);
		send_item(OP_SEARCH, 7'd0, 32'sd5);
		send_item(OP_INSERT, 7'd1, 32'sd9);
		send_item(OP_DELETE, 7'd127, -32'sd1);
	endtask

	// Inserts at head, tail and middle with extreme values, one bad position, then a traverse
	task automatic test_edge_inserts();
		send_item(OP_INSERT, 7'd0, 32'sh8000_0000);
		send_item(OP_INSERT, 7'd1, 32'sh7FFF_FFFF);
		send_item(OP_INSERT, 7'd0, -32'sd1);
		send_item(OP_INSERT, 7'd1, 32'sd0);
		send_item(OP_INSERT, 7'd2, 32'sh5555_5555);
		send_item(OP_INSERT, 7'd5, 32'shAAAA_AAAA);
		send_item(OP_INSERT, 7'd7, 32'sd3);
		send_item(OP_TRAVERSE, 7'd127, 32'sd0);
	endtask

	// Hits, a duplicate resolving to the lowest index, and a miss
	task automatic test_search();
		send_item(OP_INSERT, 7'd3, 32'sh7FFF_FFFF);
		send_item(OP_SEARCH, 7'd64, 32'sh7FFF_FFFF);
		send_item(OP_SEARCH, 7'd0, 32'sh8000_0000);
		send_item(OP_SEARCH, 7'd0, 32'sd12345);
		send_item(OP_SEARCH, 7'd0, 32'sd0);
	endtask

	// Deletes at tail, head and middle, plus one past the end
	task automatic test_delete();
		send_item(OP_DELETE, POS_W'(shadow_list.size()), 32'sd0);
		send_item(OP_DELETE, POS_W'(shadow_list.size() - 1), 32'sd0);
		send_item(OP_DELETE, 7'd0, 32'sd0);
		send_item(OP_DELETE, 7'd1, 32'sd0);
		send_item(OP_TRAVERSE, 7'd0, 32'sd0);
	endtask

	// Receiver holds off while items keep coming, so the input stalls
	task automatic test_backpressure();
		tx_quiet = 1'b1;
		rx_hold = 200;
		for (int i = 0; i < 8; i++)
			send_item(OP_INSERT, POS_W'($urandom_range(0, shadow_list.size())), pick_value());
		send_item(OP_TRAVERSE, 7'd0, 32'sd0);
		send_item(OP_SEARCH, 7'd0, shadow_list[0]);
		send_item(OP_DELETE, 7'd0, 32'sd0);
		send_item(OP_SEARCH, 7'd0, pick_value());
		wait_drained();
		tx_quiet = 1'b0;
	endtask

	// Fill to capacity, probe full and bad positions, then drain down
	task automatic test_full_list();
		while (shadow_list.size() < DEPTH)
			send_item(OP_INSERT, POS_W'($urandom_range(0, shadow_list.size())), pick_value());
		send_item(OP_INSERT, POS_W'(DEPTH), 32'sd1);
		send_item(OP_INSERT, 7'd0, 32'sd2);
		send_item(OP_INSERT, POS_W'(DEPTH + 1), 32'sd3);
		send_item(OP_INSERT, 7'd127, 32'sd4);
		send_item(OP_SEARCH, 7'd0, shadow_list[DEPTH-1]);
		send_item(OP_TRAVERSE, 7'd0, 32'sd0);
		send_item(OP_DELETE, POS_W'(DEPTH), 32'sd0);
		send_item(OP_DELETE, POS_W'(DEPTH - 1), 32'sd0);
		while (shadow_list.size() > 10)
			send_item(OP_DELETE, POS_W'($urandom_range(0, shadow_list.size() - 1)),
				pick_value());
	endtask

	// Random operations, list size steered toward a moving target
	task automatic test_random_mix(int n_items);
		int target;
		int sel;
		int n;
		op_t op;
		logic [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		target = 0;
		for (int k = 0; k < n_items; k++) begin
			if (k % 32 == 0) begin
				target = ($urandom_range(0, 3) == 0) ? $urandom_range(40, DEPTH)
					: $urandom_range(0, 16);
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			n = shadow_list.size();
			sel = $urandom_range(0, 99);
			if (sel < 12)
				op = OP_TRAVERSE;
			else if (sel < 32)
				op = OP_SEARCH;
			else if (n < target)
				op = (sel < 80) ? OP_INSERT : OP_DELETE;
			else
				op = (sel < 80) ? OP_DELETE : OP_INSERT;
			// Mostly legal positions, some anywhere in the field
			pos = POS_W'($urandom_range(0, 127));
			if ($urandom_range(0, 9) != 0) begin
				if (op == OP_INSERT)
					pos = POS_W'($urandom_range(0, n));
				else if (op == OP_DELETE && n > 0)
					pos = POS_W'($urandom_range(0, n - 1));
			end
			if (op == OP_SEARCH && n > 0 && $urandom_range(0, 9) < 6)
				val = shadow_list[$urandom_range(0, n - 1)];
			else
				val = pick_value();
			send_item(op, pos, val);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Receiver: random stall per result, plus a long hold on request
	initial begin : rx_side
		int w;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = rx_quiet ? 0 : $urandom_range(0, 19);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall) && rx_hold == 0);
		end
	end

	// Field compare with report
	task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Result checker: each taken result against the oldest prediction
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected: status %0d index %0d count %0d",
					status, index, count);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				check_field("status", VAL_W'(e.status), VAL_W'(status));
				check_field("index", VAL_W'(e.index), VAL_W'(index));
				check_field("element", e.element, element);
				check_field("count", VAL_W'(e.count), VAL_W'(count));
				check_field("last", VAL_W'(e.last), VAL_W'(last));
				results_checked++;
			end
		end
	end

	// Main sequence
	initial begin : main_seq
		in_valid  = 1'b0;
		operation = OP_INSERT;
		position  = '0;
		value     = '0;
		arst_n    = 1'b0;
		items_sent = 0;
		results_checked = 0;
		traversals = 0;
		peak_length = 0;
		mismatches = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_inserts();
		test_search();
		test_delete();
		wait_drained();
		test_backpressure();
		test_full_list();
		wait_drained();
		test_random_mix(260);
		wait_drained();
		repeat (80) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end
		$display("Covered %0d items (%0d traversals), %0d results checked, peak length %0d of %0d.",
			items_sent, traversals, results_checked, peak_length, DEPTH);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
